### src/rbsi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ray against box slab test.
// No dependencies; used by ray_box_slab_intersect_core.
package rbsi_pkg;

    localparam int COORD_W   = 32;               // signed Q16.16 coordinate
    localparam int HALF_W    = 31;               // unsigned Q16.16 half extent
    localparam int DIST_W    = 31;               // unsigned Q16.16 distance
    localparam int FRAC_W    = 16;               // unsigned Q0.16 fraction
    localparam int FRAC_BITS = 16;               // fraction bits of Q16.16
    localparam int SLAB_Q_W  = COORD_W + FRAC_BITS;  // slab quotient magnitude
    localparam int T_W       = SLAB_Q_W + 1;     // signed slab parameter
    localparam int PROD_W    = 2 * COORD_W;      // direction times distance
    localparam int CMP_W     = COORD_W + HALF_W; // |point| times half extent
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 6;                // entry and exit per axis

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_X = 2'd0,
        CFG_HALF_Y = 2'd1,
        CFG_HALF_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        NORMAL_X = 2'd0,
        NORMAL_Y = 2'd1,
        NORMAL_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][COORD_W-1:0] dir;
        logic [DIST_W-1:0]       max_dist;
    } t_ray;

    typedef struct packed {
        t_ray             ray;
        logic             cont_miss;
        logic [2:0]       dzero;
        logic [LANES-1:0] qneg;
    } t_slab_side;

    typedef struct packed {
        logic                    hit;
        logic [2:0][COORD_W-1:0] point;
        t_axis                   axis;
        logic                    neg;
    } t_hit_side;

endpackage

### src/rbsi_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing a valid bit and a sideband word. Standalone; no package needed.
module rbsi_div_pipe #(
    parameter int LANES  = 1,
    parameter int Q_W    = 16,
    parameter int D_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [SIDE_W-1:0]           i_side,
    input  logic [LANES-1:0][D_W-1:0]   i_rem,
    input  logic [LANES-1:0][Q_W-1:0]   i_dvd,
    input  logic [LANES-1:0][D_W-1:0]   i_den,
    output logic                        o_valid,
    output logic [SIDE_W-1:0]           o_side,
    output logic [LANES-1:0][Q_W-1:0]   o_quo
);

    // The dividend register shifts its bits out at the top while quotient
    // bits enter at the bottom; after Q_W stages it holds the quotient.
    // The partial remainder must start below the divisor.
    logic                      r_v    [Q_W];
    logic [SIDE_W-1:0]         r_side [Q_W];
    logic [LANES-1:0][D_W-1:0] r_rem  [Q_W];
    logic [LANES-1:0][D_W-1:0] r_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0] r_dvd  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic                      pv;
        logic [SIDE_W-1:0]         pside;
        logic [LANES-1:0][D_W-1:0] prem;
        logic [LANES-1:0][D_W-1:0] pden;
        logic [LANES-1:0][Q_W-1:0] pdvd;
        logic [LANES-1:0][D_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0] n_dvd;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pside = i_side;
            assign prem  = i_rem;
            assign pden  = i_den;
            assign pdvd  = i_dvd;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pside = r_side[k-1];
            assign prem  = r_rem[k-1];
            assign pden  = r_den[k-1];
            assign pdvd  = r_dvd[k-1];
        end

        always_comb begin
            logic [D_W:0] wide;
            logic [D_W:0] diff;
            for (int l = 0; l < LANES; l++) begin
                wide = {prem[l], pdvd[l][Q_W-1]};
                diff = wide - {1'b0, pden[l]};
                // No borrow means the shifted remainder reached the divisor.
                n_rem[l] = diff[D_W] ? wide[D_W-1:0] : diff[D_W-1:0];
                n_dvd[l] = {pdvd[l][Q_W-2:0], ~diff[D_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= pside;
                r_rem[k]  <= n_rem;
                r_den[k]  <= pden;
                r_dvd[k]  <= n_dvd;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_side  = r_side[Q_W-1];
    assign o_quo   = r_dvd[Q_W-1];

endmodule

### src/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps
// Ray against origin-centered axis-aligned box, slab method, Q16.16.
// Depends on rbsi_pkg and rbsi_div_pipe.
//
//  Channel | Handshake                    | Payload
//  --------+------------------------------+-------------------------------------
//  ray in  | i_in_valid / o_in_ready      | origin xyz, dir xyz, max_dist
//  result  | o_out_valid / i_out_ready    | hit, point xyz, normal, entry_fraction
//  config  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One transaction enters per cycle unless the pipeline is frozen. Each passes
// through one input stage, 48 stages of the slab divider, five stages that
// reduce the slab parameters, five stages for the hit point and face normal,
// and 16 stages of the fraction divider. The pipeline advances as a whole and
// freezes only while a result sits at the output and is not taken.
// Reset is synchronous; it empties the pipeline and sets all half extents
// to 1.0. Configuration writes are always taken.
module ray_box_slab_intersect_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbsi_pkg::HALF_W-1:0]       i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_origin_z,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_dir_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_dir_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0] i_dir_z,
    input  logic [rbsi_pkg::DIST_W-1:0]       i_max_dist,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [rbsi_pkg::COORD_W-1:0] o_point_x,
    output logic signed [rbsi_pkg::COORD_W-1:0] o_point_y,
    output logic signed [rbsi_pkg::COORD_W-1:0] o_point_z,
    output logic [1:0]                        o_normal_axis,
    output logic                              o_normal_negative,
    output logic [rbsi_pkg::FRAC_W-1:0]       o_entry_fraction
);
    import rbsi_pkg::*;

    function automatic logic signed [T_W-1:0] smax(input logic signed [T_W-1:0] a,
                                                   input logic signed [T_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [T_W-1:0] smin(input logic signed [T_W-1:0] a,
                                                   input logic signed [T_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // The whole pipeline moves together whenever the output register is
    // free or its result is being taken.
    logic en;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // Half extent registers.
    logic [2:0][HALF_W-1:0] r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= {3{HALF_RESET}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_X: r_half[0] <= i_cfg_data;
                CFG_HALF_Y: r_half[1] <= i_cfg_data;
                CFG_HALF_Z: r_half[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: slab numerators (bound - origin) as sign and magnitude,
    // direction magnitudes, and the containment check for zero directions.
    t_slab_side                      s0_side;
    logic [LANES-1:0][SLAB_Q_W-1:0]  s0_dvd;
    logic [LANES-1:0][COORD_W-1:0]   s0_den;

    always_comb begin
        logic signed [COORD_W+1:0] o_e;
        logic signed [COORD_W+1:0] h_e;
        logic signed [COORD_W+1:0] a_lo;
        logic signed [COORD_W+1:0] a_hi;
        logic signed [COORD_W+1:0] m_lo;
        logic signed [COORD_W+1:0] m_hi;
        logic [COORD_W-1:0]        d_mag;
        s0_side.ray.org      = {i_origin_z, i_origin_y, i_origin_x};
        s0_side.ray.dir      = {i_dir_z, i_dir_y, i_dir_x};
        s0_side.ray.max_dist = i_max_dist;
        s0_side.cont_miss    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            o_e  = (COORD_W+2)'($signed(s0_side.ray.org[i]));
            h_e  = $signed({3'b000, r_half[i]});
            a_lo = -h_e - o_e;
            a_hi = h_e - o_e;
            m_lo = a_lo[COORD_W+1] ? -a_lo : a_lo;
            m_hi = a_hi[COORD_W+1] ? -a_hi : a_hi;
            d_mag = s0_side.ray.dir[i][COORD_W-1] ? -s0_side.ray.dir[i]
                                                  : s0_side.ray.dir[i];
            s0_side.dzero[i]      = (s0_side.ray.dir[i] == '0);
            s0_side.qneg[2*i]     = a_lo[COORD_W+1] ^ s0_side.ray.dir[i][COORD_W-1];
            s0_side.qneg[2*i+1]   = a_hi[COORD_W+1] ^ s0_side.ray.dir[i][COORD_W-1];
            s0_dvd[2*i]           = {m_lo[COORD_W-1:0], FRAC_BITS'(0)};
            s0_dvd[2*i+1]         = {m_hi[COORD_W-1:0], FRAC_BITS'(0)};
            s0_den[2*i]           = d_mag;
            s0_den[2*i+1]         = d_mag;
            if (s0_side.dzero[i] && ((o_e < -h_e) || (o_e > h_e))) begin
                s0_side.cont_miss = 1'b1;
            end
        end
    end

    logic                           r_s0_v;
    t_slab_side                     r_s0_side;
    logic [LANES-1:0][SLAB_Q_W-1:0] r_s0_dvd;
    logic [LANES-1:0][COORD_W-1:0]  r_s0_den;

    // Six slab divisions in parallel: entry and exit bound of each axis.
    logic                           slab_v;
    logic [$bits(t_slab_side)-1:0]  slab_side_bits;
    t_slab_side                     slab_side;
    logic [LANES-1:0][SLAB_Q_W-1:0] slab_quo;

    rbsi_div_pipe #(
        .LANES  (LANES),
        .Q_W    (SLAB_Q_W),
        .D_W    (COORD_W),
        .SIDE_W ($bits(t_slab_side))
    ) u_slab_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_side  (r_s0_side),
        .i_rem   ('0),
        .i_dvd   (r_s0_dvd),
        .i_den   (r_s0_den),
        .o_valid (slab_v),
        .o_side  (slab_side_bits),
        .o_quo   (slab_quo)
    );

    assign slab_side = t_slab_side'(slab_side_bits);

    // Reduction stages: signed slab parameters, per-axis entry and exit,
    // then tmin and tmax, then the hit decision. An axis with zero
    // direction contributes the neutral values 0 and max_dist.
    logic                    r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v;
    t_slab_side              r_p1_side, r_p2_side, r_p3_side, r_p4_side;
    logic signed [T_W-1:0]   r_p1_t  [LANES];
    logic signed [T_W-1:0]   r_p2_lo [3];
    logic signed [T_W-1:0]   r_p2_hi [3];
    logic signed [T_W-1:0]   r_p3_a, r_p3_b, r_p3_c, r_p3_e;
    logic signed [T_W-1:0]   r_p4_tmin, r_p4_tmax;
    t_ray                    r_p5_ray;
    logic                    r_p5_hit;
    logic [DIST_W-1:0]       r_p5_tm;

    logic signed [T_W-1:0]   p3_m;
    logic signed [T_W-1:0]   p4_m;
    assign p3_m = $signed({(T_W-DIST_W)'(0), r_p2_side.ray.max_dist});
    assign p4_m = $signed({(T_W-DIST_W)'(0), r_p4_side.ray.max_dist});

    // Point and normal stages.
    logic                         r_m1_v, r_m2_v, r_m3_v, r_m4_v, r_m5_v;
    t_ray                         r_m1_ray;
    logic                         r_m1_hit, r_m2_hit, r_m3_hit, r_m4_hit;
    logic [DIST_W-1:0]            r_m1_tm, r_m2_tm, r_m3_tm, r_m4_tm;
    logic [DIST_W-1:0]            r_m2_m, r_m3_m, r_m4_m;
    logic signed [PROD_W-1:0]     r_m1_prod [3];
    logic [2:0][COORD_W-1:0]      r_m2_p, r_m3_p, r_m4_p;
    logic [2:0][COORD_W-1:0]      r_m3_ap;
    logic [CMP_W-1:0]             r_m4_xy, r_m4_yx, r_m4_xz, r_m4_zx, r_m4_yz, r_m4_zy;
    t_hit_side                    r_m5_side;
    logic [DIST_W-1:0]            r_m5_rem;
    logic [DIST_W-1:0]            r_m5_den;

    logic [2:0][COORD_W-1:0]      n_m2_p;
    t_hit_side                    n_m5_side;

    always_comb begin
        logic signed [PROD_W-1:0] sum;
        for (int i = 0; i < 3; i++) begin
            // Arithmetic shift is the floor of the division by 65536.
            sum = PROD_W'($signed(r_m1_ray.org[i])) + (r_m1_prod[i] >>> FRAC_BITS);
            if ((&sum[PROD_W-1:COORD_W-1]) || !(|sum[PROD_W-1:COORD_W-1])) begin
                n_m2_p[i] = sum[COORD_W-1:0];
            end else begin
                n_m2_p[i] = sum[PROD_W-1] ? {1'b1, (COORD_W-1)'(0)}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        logic x_ge_y;
        logic x_ge_z;
        logic y_ge_z;
        logic [COORD_W-1:0] pa;
        x_ge_y = (r_m4_xy >= r_m4_yx);
        x_ge_z = (r_m4_xz >= r_m4_zx);
        y_ge_z = (r_m4_yz >= r_m4_zy);
        if (x_ge_y && x_ge_z) begin
            n_m5_side.axis = NORMAL_X;
            pa = r_m4_p[0];
        end else if (y_ge_z) begin
            n_m5_side.axis = NORMAL_Y;
            pa = r_m4_p[1];
        end else begin
            n_m5_side.axis = NORMAL_Z;
            pa = r_m4_p[2];
        end
        n_m5_side.neg   = pa[COORD_W-1] || (pa == '0);
        n_m5_side.point = r_m4_p;
        n_m5_side.hit   = r_m4_hit;
        // A miss reports all zeros.
        if (!r_m4_hit) begin
            n_m5_side.axis  = NORMAL_X;
            n_m5_side.neg   = 1'b0;
            n_m5_side.point = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
            r_m5_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in_valid;
            r_p1_v <= slab_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
            r_m1_v <= r_p5_v;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
            r_m5_v <= r_m4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side <= s0_side;
            r_s0_dvd  <= s0_dvd;
            r_s0_den  <= s0_den;

            r_p1_side <= slab_side;
            for (int l = 0; l < LANES; l++) begin
                r_p1_t[l] <= slab_side.qneg[l] ? -$signed({1'b0, slab_quo[l]})
                                               :  $signed({1'b0, slab_quo[l]});
            end

            r_p2_side <= r_p1_side;
            for (int i = 0; i < 3; i++) begin
                if (r_p1_side.dzero[i]) begin
                    r_p2_lo[i] <= '0;
                    r_p2_hi[i] <= $signed({(T_W-DIST_W)'(0), r_p1_side.ray.max_dist});
                end else begin
                    r_p2_lo[i] <= smin(r_p1_t[2*i], r_p1_t[2*i+1]);
                    r_p2_hi[i] <= smax(r_p1_t[2*i], r_p1_t[2*i+1]);
                end
            end

            r_p3_side <= r_p2_side;
            r_p3_a    <= smax(r_p2_lo[0], r_p2_lo[1]);
            r_p3_b    <= smax(r_p2_lo[2], '0);
            r_p3_c    <= smin(r_p2_hi[0], r_p2_hi[1]);
            r_p3_e    <= smin(r_p2_hi[2], p3_m);

            r_p4_side <= r_p3_side;
            r_p4_tmin <= smax(r_p3_a, r_p3_b);
            r_p4_tmax <= smin(r_p3_c, r_p3_e);

            r_p5_ray <= r_p4_side.ray;
            if (!r_p4_side.cont_miss && (r_p4_tmin <= r_p4_tmax)
                    && (r_p4_tmin > 0) && (r_p4_tmin < p4_m)) begin
                r_p5_hit <= 1'b1;
                r_p5_tm  <= r_p4_tmin[DIST_W-1:0];
            end else begin
                r_p5_hit <= 1'b0;
                r_p5_tm  <= '0;
            end

            r_m1_ray <= r_p5_ray;
            r_m1_hit <= r_p5_hit;
            r_m1_tm  <= r_p5_tm;
            for (int i = 0; i < 3; i++) begin
                r_m1_prod[i] <= PROD_W'($signed(r_p5_ray.dir[i]))
                              * PROD_W'($signed({1'b0, r_p5_tm}));
            end

            r_m2_p   <= n_m2_p;
            r_m2_hit <= r_m1_hit;
            r_m2_tm  <= r_m1_tm;
            r_m2_m   <= r_m1_ray.max_dist;

            for (int i = 0; i < 3; i++) begin
                r_m3_ap[i] <= r_m2_p[i][COORD_W-1] ? -r_m2_p[i] : r_m2_p[i];
            end
            r_m3_p   <= r_m2_p;
            r_m3_hit <= r_m2_hit;
            r_m3_tm  <= r_m2_tm;
            r_m3_m   <= r_m2_m;

            // Compare |p_a| / h_a across axes by cross multiplication.
            r_m4_xy  <= CMP_W'(r_m3_ap[0]) * CMP_W'(r_half[1]);
            r_m4_yx  <= CMP_W'(r_m3_ap[1]) * CMP_W'(r_half[0]);
            r_m4_xz  <= CMP_W'(r_m3_ap[0]) * CMP_W'(r_half[2]);
            r_m4_zx  <= CMP_W'(r_m3_ap[2]) * CMP_W'(r_half[0]);
            r_m4_yz  <= CMP_W'(r_m3_ap[1]) * CMP_W'(r_half[2]);
            r_m4_zy  <= CMP_W'(r_m3_ap[2]) * CMP_W'(r_half[1]);
            r_m4_p   <= r_m3_p;
            r_m4_hit <= r_m3_hit;
            r_m4_tm  <= r_m3_tm;
            r_m4_m   <= r_m3_m;

            // On a miss the fraction divides zero by one, giving zero.
            r_m5_side <= n_m5_side;
            r_m5_rem  <= r_m4_tm;
            r_m5_den  <= r_m4_hit ? r_m4_m : DIST_W'(1);
        end
    end

    // The entry fraction is tmin * 65536 / max_dist; tmin below max_dist
    // keeps the quotient within 16 bits.
    logic                          frac_v;
    logic [$bits(t_hit_side)-1:0]  frac_side_bits;
    t_hit_side                     frac_side;
    logic [0:0][FRAC_W-1:0]        frac_quo;

    rbsi_div_pipe #(
        .LANES  (1),
        .Q_W    (FRAC_W),
        .D_W    (DIST_W),
        .SIDE_W ($bits(t_hit_side))
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m5_v),
        .i_side  (r_m5_side),
        .i_rem   (r_m5_rem),
        .i_dvd   ('0),
        .i_den   (r_m5_den),
        .o_valid (frac_v),
        .o_side  (frac_side_bits),
        .o_quo   (frac_quo)
    );

    assign frac_side         = t_hit_side'(frac_side_bits);
    assign o_out_valid       = frac_v;
    assign o_hit             = frac_side.hit;
    assign o_point_x         = frac_side.point[0];
    assign o_point_y         = frac_side.point[1];
    assign o_point_z         = frac_side.point[2];
    assign o_normal_axis     = frac_side.axis;
    assign o_normal_negative = frac_side.neg;
    assign o_entry_fraction  = frac_quo[0];

`ifndef SYNTHESIS
    // A miss leaves every result field at zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_point_x == 0) && (o_point_y == 0)
            && (o_point_z == 0) && (o_normal_axis == NORMAL_X)
            && !o_normal_negative && (o_entry_fraction == 0))
        else $error("miss result carries nonzero fields");

    // A hit decision always has tmin strictly inside the range.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p5_v && r_p5_hit |-> (r_p5_tm != 0) && (r_p5_tm < r_p5_ray.max_dist))
        else $error("hit with tmin outside (0, max_dist)");

    // For a hit on the x face, the normal sign agrees with point x.
    a_neg_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit && (o_normal_axis == NORMAL_X)
            |-> o_normal_negative == !(o_point_x > 0))
        else $error("normal sign disagrees with point x");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule
